// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lsab_pkg.sv =====
// ----------------------------------------------------------------------------
// lsab_pkg
// Constants and level-to-timing maps for the level scaled alarm beeper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsab_pkg;

  localparam logic [7:0] LevelMin   = 8'd20;
  localparam logic [7:0] LevelMax   = 8'd100;
  localparam logic [7:0] OnSlow     = 8'd200;
  localparam logic [7:0] OffSlow    = 8'd200;
  localparam logic [3:0] RepeatFew  = 4'd3;
  localparam logic [3:0] BeepsMax   = 4'd10;

  typedef logic [6:0] level_ofs_t;   // clamped level minus LevelMin, 0..80
  typedef logic [7:0] dur_ms_t;      // on/off durations, 30..200
  typedef logic [3:0] count_t;       // beep counts, 0..10

  // 200 - floor(d*150/80) == 200 - floor(d*15/8)
  function automatic dur_ms_t on_time(input level_ofs_t d);
    logic [10:0] prod;
    prod = 11'(d) * 11'd15;
    return OnSlow - prod[10:3];
  endfunction

  // 200 - floor(d*170/80) == 200 - floor(d*17/8)
  function automatic dur_ms_t off_time(input level_ofs_t d);
    logic [10:0] prod;
    prod = 11'(d) * 11'd17;
    return OffSlow - prod[10:3];
  endfunction

  // 3 + floor(d*7/80): floor(x/80) = floor(floor(x/16)/5), and
  // y/5 for y <= 35 is exact as (y*13)>>6.
  function automatic count_t repeat_total(input level_ofs_t d);
    logic [9:0]  prod;
    logic [11:0] recip;
    prod  = 10'(d) * 10'd7;
    recip = 12'(prod[9:4]) * 12'd13;
    return RepeatFew + recip[9:6];
  endfunction

endpackage

// ===== rtl/core/level_scaled_alarm_beeper.sv =====
// ----------------------------------------------------------------------------
// level_scaled_alarm_beeper
// Level-driven beep pattern sequencer with a registered result.
// ----------------------------------------------------------------------------
// One result per transaction, one transaction per cycle when the output side
// keeps up; out_valid rises in the cycle after input accept. The level is
// clamped to 20..100 and sets the on time, off time and repeat total; the
// buzzer state, last change time and beep count update at the input accept
// and the new buzzer state and count sit in the output register until taken.
// Input is stalled only while a result is held and out_ready is low.
`timescale 1ns / 1ps

module level_scaled_alarm_beeper (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  level,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        buzzer_on,
  output logic [3:0]  beeps_done
);

  logic                  sounding, sounding_next;
  logic [31:0]           last_change_time, last_change_time_next;
  lsab_pkg::count_t      beep_count, beep_count_next;
  logic [7:0]            lvl_clamped;
  lsab_pkg::level_ofs_t  lvl_ofs;
  lsab_pkg::dur_ms_t     on_ms, off_ms;
  lsab_pkg::count_t      total;
  logic [31:0]           elapsed;
  logic                  accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (level < lsab_pkg::LevelMin) begin
      lvl_clamped = lsab_pkg::LevelMin;
    end else if (level > lsab_pkg::LevelMax) begin
      lvl_clamped = lsab_pkg::LevelMax;
    end else begin
      lvl_clamped = level;
    end
  end

  assign lvl_ofs = 7'(lvl_clamped - lsab_pkg::LevelMin);
  assign on_ms   = lsab_pkg::on_time(lvl_ofs);
  assign off_ms  = lsab_pkg::off_time(lvl_ofs);
  assign total   = lsab_pkg::repeat_total(lvl_ofs);
  assign elapsed = now_ms - last_change_time;   // wraps mod 2^32

  always_comb begin
    sounding_next         = sounding;
    last_change_time_next = last_change_time;
    beep_count_next       = beep_count;
    if (sounding && elapsed >= 32'(on_ms)) begin
      sounding_next         = 1'b0;
      last_change_time_next = now_ms;
      beep_count_next       = beep_count + 4'd1;
    end else if (!sounding && elapsed >= 32'(off_ms)) begin
      if (beep_count < total) begin
        sounding_next         = 1'b1;
        last_change_time_next = now_ms;
      end else begin
        beep_count_next = '0;   // pattern finished
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sounding         <= 1'b0;
      last_change_time <= '0;
      beep_count       <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (accept) begin
        sounding         <= sounding_next;
        last_change_time <= last_change_time_next;
        beep_count       <= beep_count_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buzzer_on  <= sounding_next;
      beeps_done <= beep_count_next;
    end
  end

endmodule

// ===== rtl/core/lsab_checker.sv =====
// ----------------------------------------------------------------------------
// lsab_checker
// Port-level checks for the level scaled alarm beeper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lsab_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        buzzer_on,
  input logic [3:0]  beeps_done
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(buzzer_on) && $stable(beeps_done), "result changed while stalled")
  `ASSERT_SAME(a_count_max, clk, rst, out_valid, beeps_done <= lsab_pkg::BeepsMax, "beep count above maximum")
  `ASSERT_SAME(a_stall_in, clk, rst, out_valid && !out_ready, !in_ready, "input taken while result blocked")
  `ASSERT_NEXT(a_result_next, clk, rst, in_valid && in_ready, out_valid, "accepted transaction produced no result")

endmodule

bind level_scaled_alarm_beeper lsab_checker u_lsab_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .buzzer_on  (buzzer_on),
  .beeps_done (beeps_done)
);
